FILE: src/q931_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q931_pkg
// Shared types and constants for the signalling message parser: result
// record, push bundle, kind and error codes, parser phases and sizes.
// ----------------------------------------------------------------------------
package q931_pkg;

    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int CNT_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int MIN_MESSAGE_BYTES = 5;
    localparam int MAX_REF_LENGTH    = 2;

    localparam logic [6:0] USER_USER_CODE_RESET = 7'd126;
    localparam logic [7:0] CODE_MASK            = 8'h7f;
    localparam logic [7:0] SINGLE_OCTET_BIT     = 8'h80;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_FIFO_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_HEADER       = 3'd0,
        KIND_SINGLE_OCTET = 3'd1,
        KIND_DATA         = 3'd2,
        KIND_EMPTY        = 3'd3,
        KIND_STATUS       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_TOO_SHORT   = 3'd1,
        ERR_REF_LENGTH  = 3'd2,
        ERR_UU_ZERO_LEN = 3'd3,
        ERR_OVERRUN     = 3'd4
    } err_t;

    typedef enum logic [11:0] {
        PH_PROTO  = 12'b0000_0000_0001,
        PH_REFLEN = 12'b0000_0000_0010,
        PH_REF0   = 12'b0000_0000_0100,
        PH_REF1   = 12'b0000_0000_1000,
        PH_TYPE   = 12'b0000_0001_0000,
        PH_CODE   = 12'b0000_0010_0000,
        PH_LEN    = 12'b0000_0100_0000,
        PH_UUHI   = 12'b0000_1000_0000,
        PH_UULO   = 12'b0001_0000_0000,
        PH_UUPD   = 12'b0010_0000_0000,
        PH_DATA   = 12'b0100_0000_0000,
        PH_SKIP   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  element_code;
        logic [7:0]  element_byte;
        logic        element_end;
        logic [7:0]  protocol_id;
        logic [14:0] call_ref;
        logic        from_dest;
        logic [7:0]  msg_type;
        logic        msg_ok;
        err_t        error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

FILE: src/q931_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q931_parse_core
// Message parse state and the per-byte decode: updates header and element
// state from one registered byte and builds up to two result records.
// ----------------------------------------------------------------------------
module q931_parse_core
    import q931_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] msg_byte,
    input  logic       end_of_message,
    input  logic [6:0] uu_code,
    output push_t      push
);

    phase_t            phase_reg,   phase_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [1:0]        ref_len_reg, ref_len_next;
    logic [14:0]       ref_val_reg, ref_val_next;
    logic              ref_flag_reg, ref_flag_next;
    logic [7:0]        proto_reg,   proto_next;
    logic [7:0]        type_reg,    type_next;
    logic [7:0]        code_reg,    code_next;
    logic [15:0]       rem_reg,     rem_next;
    err_t              err_reg,     err_next;

    logic              r0_valid;
    kind_t             r0_kind;
    logic [7:0]        r0_code;
    logic [7:0]        r0_byte;
    logic              r0_end;
    err_t              status_err;
    logic [15:0]       uu_len;
    result_t           res0;
    result_t           res1;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = (count_reg < CNT_W'(MAX_MESSAGE_BYTES)) ? count_reg + 1'b1 : count_reg;
        ref_len_next  = ref_len_reg;
        ref_val_next  = ref_val_reg;
        ref_flag_next = ref_flag_reg;
        proto_next    = proto_reg;
        type_next     = type_reg;
        code_next     = code_reg;
        rem_next      = rem_reg;
        err_next      = err_reg;
        r0_valid      = 1'b0;
        r0_kind       = KIND_HEADER;
        r0_code       = 8'd0;
        r0_byte       = 8'd0;
        r0_end        = 1'b0;
        uu_len        = {rem_reg[15:8], msg_byte};

        case (phase_reg)
            PH_PROTO:
            begin
                proto_next = msg_byte;
                phase_next = PH_REFLEN;
            end
            PH_REFLEN:
            begin
                if (msg_byte > 8'(MAX_REF_LENGTH))
                begin
                    if (err_reg == ERR_NONE)
                        err_next = ERR_REF_LENGTH;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    ref_len_next = msg_byte[1:0];
                    if (msg_byte == 8'd0)
                        phase_next = PH_TYPE;
                    else if (msg_byte == 8'd1)
                        phase_next = PH_REF1;
                    else
                        phase_next = PH_REF0;
                end
            end
            PH_REF0:
            begin
                ref_flag_next = msg_byte[7];
                ref_val_next  = {msg_byte[6:0] & CODE_MASK[6:0], 8'd0};
                phase_next    = PH_REF1;
            end
            PH_REF1:
            begin
                if (ref_len_reg == 2'(MAX_REF_LENGTH))
                    ref_val_next = {ref_val_reg[14:8], msg_byte};
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                type_next  = msg_byte;
                r0_valid   = 1'b1;
                r0_kind    = KIND_HEADER;
                phase_next = PH_CODE;
            end
            PH_CODE:
            begin
                code_next = msg_byte;
                if ((msg_byte & SINGLE_OCTET_BIT) != 8'd0)
                begin
                    r0_valid = 1'b1;
                    r0_kind  = KIND_SINGLE_OCTET;
                    r0_code  = msg_byte;
                end
                else if (msg_byte == {1'b0, uu_code})
                    phase_next = PH_UUHI;
                else
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                rem_next = {8'd0, msg_byte};
                if (msg_byte == 8'd0)
                begin
                    r0_valid   = 1'b1;
                    r0_kind    = KIND_EMPTY;
                    r0_code    = code_reg;
                    phase_next = PH_CODE;
                end
                else
                    phase_next = PH_DATA;
            end
            PH_UUHI:
            begin
                rem_next   = {msg_byte, 8'd0};
                phase_next = PH_UULO;
            end
            PH_UULO:
            begin
                if (uu_len == 16'd0)
                begin
                    rem_next = uu_len;
                    if (err_reg == ERR_NONE)
                        err_next = ERR_UU_ZERO_LEN;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    rem_next   = uu_len - 16'd1;
                    phase_next = PH_UUPD;
                end
            end
            PH_UUPD:
            begin
                if (rem_reg == 16'd0)
                begin
                    r0_valid   = 1'b1;
                    r0_kind    = KIND_EMPTY;
                    r0_code    = code_reg;
                    phase_next = PH_CODE;
                end
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                rem_next = rem_reg - 16'd1;
                r0_valid = 1'b1;
                r0_kind  = KIND_DATA;
                r0_code  = code_reg;
                r0_byte  = msg_byte;
                r0_end   = (rem_next == 16'd0);
                if (rem_next == 16'd0)
                    phase_next = PH_CODE;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        if (end_of_message && !(phase_next inside {PH_CODE, PH_SKIP}) && err_next == ERR_NONE)
        begin
            if (phase_next inside {PH_PROTO, PH_REFLEN, PH_REF0, PH_REF1, PH_TYPE})
                err_next = ERR_TOO_SHORT;
            else
                err_next = ERR_OVERRUN;
        end
        status_err = (count_next < CNT_W'(MIN_MESSAGE_BYTES)) ? ERR_TOO_SHORT : err_next;
    end

    always_comb
    begin
        res0.kind         = r0_kind;
        res0.element_code = r0_code;
        res0.element_byte = r0_byte;
        res0.element_end  = r0_end;
        res0.protocol_id  = proto_next;
        res0.call_ref     = ref_val_next;
        res0.from_dest    = ref_flag_next;
        res0.msg_type     = type_next;
        res0.msg_ok       = 1'b0;
        res0.error_code   = ERR_NONE;
        res0.last         = !end_of_message;

        res1.kind         = KIND_STATUS;
        res1.element_code = 8'd0;
        res1.element_byte = 8'd0;
        res1.element_end  = 1'b0;
        res1.protocol_id  = proto_next;
        res1.call_ref     = ref_val_next;
        res1.from_dest    = ref_flag_next;
        res1.msg_type     = type_next;
        res1.msg_ok       = (status_err == ERR_NONE);
        res1.error_code   = status_err;
        res1.last         = 1'b1;

        push.count  = 2'd0;
        push.first  = res0;
        push.second = res1;
        if (fire)
        begin
            if (r0_valid && end_of_message)
                push.count = 2'd2;
            else if (r0_valid)
                push.count = 2'd1;
            else if (end_of_message)
            begin
                push.count = 2'd1;
                push.first = res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PROTO;
            count_reg    <= '0;
            ref_len_reg  <= '0;
            ref_val_reg  <= '0;
            ref_flag_reg <= 1'b0;
            proto_reg    <= '0;
            type_reg     <= '0;
            code_reg     <= '0;
            rem_reg      <= '0;
            err_reg      <= ERR_NONE;
        end
        else if (fire)
        begin
            if (end_of_message)
            begin
                phase_reg    <= PH_PROTO;
                count_reg    <= '0;
                ref_len_reg  <= '0;
                ref_val_reg  <= '0;
                ref_flag_reg <= 1'b0;
                proto_reg    <= '0;
                type_reg     <= '0;
                code_reg     <= '0;
                rem_reg      <= '0;
                err_reg      <= ERR_NONE;
            end
            else
            begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                ref_len_reg  <= ref_len_next;
                ref_val_reg  <= ref_val_next;
                ref_flag_reg <= ref_flag_next;
                proto_reg    <= proto_next;
                type_reg     <= type_next;
                code_reg     <= code_next;
                rem_reg      <= rem_next;
                err_reg      <= err_next;
            end
        end
    end

    a_clear_after_status: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_message |=> phase_reg == PH_PROTO && count_reg == '0
                                   && err_reg == ERR_NONE)
        else $error("parse state not cleared after status");

    a_two_results_end_in_status: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.second.kind == KIND_STATUS && !push.first.last)
        else $error("second result of a byte is not the status");

endmodule

FILE: src/q931_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q931_result_fifo
// Small result queue: takes up to two records per cycle from the decoder
// and presents one record per transaction on the output channel.
// ----------------------------------------------------------------------------
module q931_result_fifo
    import q931_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    head_valid,
    output result_t head
);

    result_t               mem [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_FIFO_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0]      wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign room         = count_reg <= CNT_FIFO_W'(FIFO_DEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_FIFO_W'(push.count) - CNT_FIFO_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FIFO_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("result queue count lost track of a pop");

endmodule

FILE: src/q931_message_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q931_message_parser_top
// Signalling message parser: header, information elements and status.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while in_stall is low. Each accepted byte is
// held in an input register, decoded against the parse state, and its results
// (none, one, or an element/header record followed by the status record on
// the end byte) are written into a four-entry result queue. The queue drains
// one result per cycle while out_stall is low, so a byte that causes two
// results is drained as two transactions; the input stalls only when the
// queue has fewer than two free entries.
module q931_message_parser_top
    import q931_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        user_user_code_we,
    input  logic [6:0]  user_user_code_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  msg_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  element_code,
    output logic [7:0]  element_byte,
    output logic        element_end,
    output logic [7:0]  protocol_id,
    output logic [14:0] call_ref,
    output logic        from_dest,
    output logic [7:0]  msg_type,
    output logic        msg_ok,
    output logic [2:0]  error_code,
    output logic        last
);

    logic       uu_code_reg;
    logic [6:0] uu_code_val_reg;
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_eom_reg;
    logic       room;
    logic       fire;
    logic       accept_in;
    logic       pop;
    push_t      push;
    result_t    head;

    assign fire             = stage_valid_reg && room;
    assign in_stall         = stage_valid_reg && !room;
    assign accept_in        = in_valid && !in_stall;
    assign stage_valid_next = accept_in || (stage_valid_reg && !fire);
    assign pop              = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uu_code_reg     <= 1'b0;
            uu_code_val_reg <= USER_USER_CODE_RESET;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (user_user_code_we)
            begin
                uu_code_reg     <= 1'b1;
                uu_code_val_reg <= user_user_code_wdata;
            end
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            stage_byte_reg <= msg_byte;
            stage_eom_reg  <= end_of_message;
        end
    end

    q931_parse_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .msg_byte       (stage_byte_reg),
        .end_of_message (stage_eom_reg),
        .uu_code        (uu_code_val_reg),
        .push           (push)
    );

    q931_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign kind         = head.kind;
    assign element_code = head.element_code;
    assign element_byte = head.element_byte;
    assign element_end  = head.element_end;
    assign protocol_id  = head.protocol_id;
    assign call_ref     = head.call_ref;
    assign from_dest    = head.from_dest;
    assign msg_type     = head.msg_type;
    assign msg_ok       = head.msg_ok;
    assign error_code   = head.error_code;
    assign last         = head.last;

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head.kind == KIND_STATUS |-> head.last && head.element_code == 8'd0)
        else $error("status transaction not marked last");

    a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
        user_user_code_we |=> uu_code_reg && uu_code_val_reg == $past(user_user_code_wdata))
        else $error("user-user code write lost");

endmodule
